FILE: sv/prtp_pkg.sv
// Shared types, constants and helpers of the point rotate / translate / project block.
package prtp_pkg;

  // field widths
  localparam int MODE_W     = 3;
  localparam int COORD_W    = 24;
  localparam int ANGLE_W    = 17;
  localparam int SCR_W      = 16;
  localparam int WIDTH_W    = 13;
  localparam int FOCAL_W    = 12;
  localparam int NEAR_W     = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  // angle handling: input units are 2^-7 degree, CORDIC works in 2^-15 degree
  localparam int ANG_SCALE_BITS  = 15;
  localparam int ANGLE_FRAC_BITS = 7;
  localparam int ANG_SHIFT       = ANG_SCALE_BITS - ANGLE_FRAC_BITS;
  localparam int RED_W           = ANGLE_W + ANG_SHIFT + 1;
  localparam int ANG_W           = 24;
  localparam int CV_W            = 32;
  localparam int CORDIC_STEPS    = 16;

  localparam logic signed [RED_W-1:0] FULL_TURN    = RED_W'(360 << ANG_SCALE_BITS);
  localparam logic signed [RED_W-1:0] HALF_TURN    = RED_W'(180 << ANG_SCALE_BITS);
  localparam logic signed [RED_W-1:0] QUARTER_TURN = RED_W'(90 << ANG_SCALE_BITS);

  localparam logic signed [CV_W-1:0] CORDIC_START = 32'sd652032874;

  localparam logic signed [ANG_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
    24'sd1474560, 24'sd870484, 24'sd459940, 24'sd233473,
    24'sd117189,  24'sd58652,  24'sd29333,  24'sd14667,
    24'sd7334,    24'sd3667,   24'sd1833,   24'sd917,
    24'sd458,     24'sd229,    24'sd115,    24'sd57
  };

  // product / rounding widths
  localparam int PROD_W     = COORD_W + CV_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int PROD_SHIFT = 30;
  localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(64'sd1 <<< (PROD_SHIFT - 1));

  // projection widths
  localparam int CTR_W = WIDTH_W - 1;
  localparam int D_W   = COORD_W - 1;
  localparam int CD_W  = CTR_W + D_W;
  localparam int NF_W  = COORD_W + FOCAL_W + 1;
  localparam int NUM_W = 38;
  localparam int MAG_W = NUM_W;
  localparam int Q_W   = SCR_W + 1;
  localparam int CMP_W = D_W + Q_W;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_ROT_X  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ROT_Y  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_ROT_Z  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MOVE_X = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MOVE_Y = 3'd4;
  localparam logic [MODE_W-1:0] MODE_MOVE_Z = 3'd5;
  localparam logic [MODE_W-1:0] MODE_PASS   = 3'd6;

  // register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL  = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR   = 8'd3;

  localparam logic [WIDTH_W-1:0] RST_WIDTH  = 13'd800;
  localparam logic [WIDTH_W-1:0] RST_HEIGHT = 13'd600;
  localparam logic [FOCAL_W-1:0] RST_FOCAL  = 12'd500;
  localparam logic [NEAR_W-1:0]  RST_NEAR   = 16'd256;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SCR_W-1:0]   scr_t;
  typedef logic signed [ANG_W-1:0]   ang_t;
  typedef logic signed [CV_W-1:0]    cval_t;

  localparam coord_t COORD_MAX = 24'sh7FFFFF;
  localparam coord_t COORD_MIN = 24'sh800000;
  localparam scr_t   SCR_MAX   = 16'sh7FFF;
  localparam scr_t   SCR_MIN   = 16'sh8000;

  typedef enum logic [1:0] {OP_ROT, OP_MOVE, OP_PASS} op_e;
  typedef enum logic [1:0] {AXIS_X, AXIS_Y, AXIS_Z} axis_e;

  // classified word handed from front to back
  typedef struct packed {
    op_e    op;
    axis_e  axis;
    logic   flip;
    ang_t   ang;
    coord_t x;
    coord_t y;
    coord_t z;
    coord_t off;
  } qword_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } pt_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
    scr_t   sx;
    scr_t   sy;
  } res_t;

  typedef struct packed {
    logic [WIDTH_W-1:0] width;
    logic [WIDTH_W-1:0] height;
    logic [FOCAL_W-1:0] focal;
    logic [NEAR_W-1:0]  near_depth;
  } cfg_t;

  // clamp a wide signed value to the coordinate range
  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    coord_t r;
    if (v > SUM_W'(COORD_MAX)) begin
      r = COORD_MAX;
    end else if (v < SUM_W'(COORD_MIN)) begin
      r = COORD_MIN;
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

endpackage

FILE: sv/prtp_fifo.sv
// Two-entry register queue used between pipeline sections.
module prtp_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wptr_q, rptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (do_push) wptr_q <= ~wptr_q;
      if (do_pop)  rptr_q <= ~rptr_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end

endmodule

FILE: sv/prtp_front.sv
// Front end: takes a word, decodes the mode and reduces the angle to a half turn.
module prtp_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push_i,
  output logic                            full_o,
  input  logic [prtp_pkg::MODE_W-1:0]     mode_i,
  input  prtp_pkg::coord_t                in_x_i,
  input  prtp_pkg::coord_t                in_y_i,
  input  prtp_pkg::coord_t                in_z_i,
  input  logic signed [prtp_pkg::ANGLE_W-1:0] angle_i,
  input  prtp_pkg::coord_t                offset_i,
  input  logic                            qfull_i,
  output logic                            qpush_o,
  output prtp_pkg::qword_t                qword_o
);

  logic             v_q;
  prtp_pkg::qword_t w_q, w_d;
  logic             accept, move;
  logic signed [prtp_pkg::RED_W-1:0] a, r1, r2;
  logic             flip;

  assign full_o  = v_q && qfull_i;
  assign move    = v_q && !qfull_i;
  assign accept  = push_i && !full_o;
  assign qpush_o = move;
  assign qword_o = w_q;

  // decode and angle reduction into (-90, 90] degrees plus a sign flip
  always_comb begin
    a = {{(prtp_pkg::RED_W - prtp_pkg::ANGLE_W - prtp_pkg::ANG_SHIFT){angle_i[prtp_pkg::ANGLE_W-1]}},
         angle_i, {prtp_pkg::ANG_SHIFT{1'b0}}};
    if (a > prtp_pkg::HALF_TURN) begin
      r1 = a - prtp_pkg::FULL_TURN;
    end else if (a <= -prtp_pkg::HALF_TURN) begin
      r1 = a + prtp_pkg::FULL_TURN;
    end else begin
      r1 = a;
    end
    flip = 1'b0;
    priority if (r1 > prtp_pkg::QUARTER_TURN) begin
      r2   = r1 - prtp_pkg::HALF_TURN;
      flip = 1'b1;
    end else if (r1 <= -prtp_pkg::QUARTER_TURN) begin
      r2   = r1 + prtp_pkg::HALF_TURN;
      flip = 1'b1;
    end else begin
      r2 = r1;
    end

    w_d.flip = flip;
    w_d.ang  = prtp_pkg::ANG_W'(r2);
    w_d.x    = in_x_i;
    w_d.y    = in_y_i;
    w_d.z    = in_z_i;
    w_d.off  = offset_i;
    unique case (mode_i)
      prtp_pkg::MODE_ROT_X:  begin w_d.op = prtp_pkg::OP_ROT;  w_d.axis = prtp_pkg::AXIS_X; end
      prtp_pkg::MODE_ROT_Y:  begin w_d.op = prtp_pkg::OP_ROT;  w_d.axis = prtp_pkg::AXIS_Y; end
      prtp_pkg::MODE_ROT_Z:  begin w_d.op = prtp_pkg::OP_ROT;  w_d.axis = prtp_pkg::AXIS_Z; end
      prtp_pkg::MODE_MOVE_X: begin w_d.op = prtp_pkg::OP_MOVE; w_d.axis = prtp_pkg::AXIS_X; end
      prtp_pkg::MODE_MOVE_Y: begin w_d.op = prtp_pkg::OP_MOVE; w_d.axis = prtp_pkg::AXIS_Y; end
      prtp_pkg::MODE_MOVE_Z: begin w_d.op = prtp_pkg::OP_MOVE; w_d.axis = prtp_pkg::AXIS_Z; end
      prtp_pkg::MODE_PASS:   begin w_d.op = prtp_pkg::OP_PASS; w_d.axis = prtp_pkg::AXIS_X; end
      default:               begin w_d.op = prtp_pkg::OP_PASS; w_d.axis = prtp_pkg::AXIS_X; end
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (accept) begin
      v_q <= 1'b1;
    end else if (move) begin
      v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) w_q <= w_d;
  end

endmodule

FILE: sv/prtp_rotate.sv
// Back end transform: CORDIC sin/cos pipeline, products, rounding and translation.
module prtp_rotate (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             in_valid_i,
  input  prtp_pkg::qword_t in_word_i,
  output logic             out_valid_o,
  output prtp_pkg::pt_t    out_pt_o
);

  localparam int N  = prtp_pkg::CORDIC_STEPS;
  localparam int TW = prtp_pkg::COORD_W + 1;

  typedef struct packed {
    prtp_pkg::op_e    op;
    prtp_pkg::axis_e  axis;
    logic             flip;
    prtp_pkg::ang_t   ang;
    prtp_pkg::cval_t  cx;
    prtp_pkg::cval_t  cy;
    prtp_pkg::coord_t x;
    prtp_pkg::coord_t y;
    prtp_pkg::coord_t z;
    prtp_pkg::coord_t off;
  } cstg_t;

  cstg_t      stg_q [N+1];
  logic [N:0] sv_q;

  // CORDIC entry stage
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      stg_q[0].op   <= in_word_i.op;
      stg_q[0].axis <= in_word_i.axis;
      stg_q[0].flip <= in_word_i.flip;
      stg_q[0].ang  <= in_word_i.ang;
      stg_q[0].cx   <= prtp_pkg::CORDIC_START;
      stg_q[0].cy   <= '0;
      stg_q[0].x    <= in_word_i.x;
      stg_q[0].y    <= in_word_i.y;
      stg_q[0].z    <= in_word_i.z;
      stg_q[0].off  <= in_word_i.off;
    end
  end

  // one CORDIC iteration per stage
  for (genvar i = 0; i < N; i++) begin : g_cordic
    prtp_pkg::cval_t xc, yc;
    prtp_pkg::ang_t  ac;
    cstg_t           nxt;
    assign xc = stg_q[i].cx;
    assign yc = stg_q[i].cy;
    assign ac = stg_q[i].ang;
    always_comb begin
      nxt = stg_q[i];
      if (ac >= 0) begin
        nxt.cx  = xc - (yc >>> i);
        nxt.cy  = yc + (xc >>> i);
        nxt.ang = ac - prtp_pkg::ATAN_TAB[i];
      end else begin
        nxt.cx  = xc + (yc >>> i);
        nxt.cy  = yc - (xc >>> i);
        nxt.ang = ac + prtp_pkg::ATAN_TAB[i];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) stg_q[i+1] <= nxt;
    end
  end

  // products of the two rotated coordinates with cos and sin
  typedef struct packed {
    prtp_pkg::op_e    op;
    prtp_pkg::axis_e  axis;
    logic             flip;
    prtp_pkg::coord_t x;
    prtp_pkg::coord_t y;
    prtp_pkg::coord_t z;
    prtp_pkg::coord_t off;
  } mpay_t;

  mpay_t m_q;
  logic  mv_q;
  logic signed [prtp_pkg::PROD_W-1:0] pac_q, pbs_q, pas_q, pbc_q;
  prtp_pkg::coord_t ca, cb;
  prtp_pkg::cval_t  cc, cs;

  assign cc = stg_q[N].cx;
  assign cs = stg_q[N].cy;

  always_comb begin
    unique case (stg_q[N].axis)
      prtp_pkg::AXIS_X: begin ca = stg_q[N].y; cb = stg_q[N].z; end
      prtp_pkg::AXIS_Y: begin ca = stg_q[N].z; cb = stg_q[N].x; end
      prtp_pkg::AXIS_Z: begin ca = stg_q[N].x; cb = stg_q[N].y; end
      default:          begin ca = stg_q[N].x; cb = stg_q[N].y; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m_q.op   <= stg_q[N].op;
      m_q.axis <= stg_q[N].axis;
      m_q.flip <= stg_q[N].flip;
      m_q.x    <= stg_q[N].x;
      m_q.y    <= stg_q[N].y;
      m_q.z    <= stg_q[N].z;
      m_q.off  <= stg_q[N].off;
      pac_q    <= prtp_pkg::PROD_W'(ca) * prtp_pkg::PROD_W'(cc);
      pbs_q    <= prtp_pkg::PROD_W'(cb) * prtp_pkg::PROD_W'(cs);
      pas_q    <= prtp_pkg::PROD_W'(ca) * prtp_pkg::PROD_W'(cs);
      pbc_q    <= prtp_pkg::PROD_W'(cb) * prtp_pkg::PROD_W'(cc);
    end
  end

  // sums, rounding, saturation and translation
  logic signed [prtp_pkg::SUM_W-1:0] ea, eb, ec, ed, sa, sb, ta, tb, ra, rb;
  prtp_pkg::coord_t qa, qb, mx, my, mz, mo;
  logic signed [prtp_pkg::COORD_W:0] tx, ty, tz;
  prtp_pkg::pt_t r_d, r_q;
  logic          rv_q;

  always_comb begin
    ea = prtp_pkg::SUM_W'(pac_q);
    eb = prtp_pkg::SUM_W'(pbs_q);
    ec = prtp_pkg::SUM_W'(pas_q);
    ed = prtp_pkg::SUM_W'(pbc_q);
    // with the flip flag both cos and sin change sign, so the sums do too
    sa = m_q.flip ? (eb - ea) : (ea - eb);
    sb = m_q.flip ? (-ec - ed) : (ec + ed);
    ta = sa + prtp_pkg::ROUND_HALF;
    tb = sb + prtp_pkg::ROUND_HALF;
    ra = ta >>> prtp_pkg::PROD_SHIFT;
    rb = tb >>> prtp_pkg::PROD_SHIFT;
    qa = prtp_pkg::sat_coord(ra);
    qb = prtp_pkg::sat_coord(rb);
    mx = m_q.x;
    my = m_q.y;
    mz = m_q.z;
    mo = m_q.off;
    tx = TW'(mx) + TW'(mo);
    ty = TW'(my) + TW'(mo);
    tz = TW'(mz) + TW'(mo);
    r_d.x = mx;
    r_d.y = my;
    r_d.z = mz;
    unique case (m_q.op)
      prtp_pkg::OP_ROT: begin
        unique case (m_q.axis)
          prtp_pkg::AXIS_X: begin r_d.y = qa; r_d.z = qb; end
          prtp_pkg::AXIS_Y: begin r_d.z = qa; r_d.x = qb; end
          prtp_pkg::AXIS_Z: begin r_d.x = qa; r_d.y = qb; end
          default: ;
        endcase
      end
      prtp_pkg::OP_MOVE: begin
        unique case (m_q.axis)
          prtp_pkg::AXIS_X: r_d.x = prtp_pkg::sat_coord(prtp_pkg::SUM_W'(tx));
          prtp_pkg::AXIS_Y: r_d.y = prtp_pkg::sat_coord(prtp_pkg::SUM_W'(ty));
          prtp_pkg::AXIS_Z: r_d.z = prtp_pkg::sat_coord(prtp_pkg::SUM_W'(tz));
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en_i) r_q <= r_d;
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      mv_q <= 1'b0;
      rv_q <= 1'b0;
    end else if (en_i) begin
      sv_q <= {sv_q[N-1:0], in_valid_i};
      mv_q <= sv_q[N];
      rv_q <= mv_q;
    end
  end

  assign out_valid_o = rv_q;
  assign out_pt_o    = r_q;

endmodule

FILE: sv/prtp_project.sv
// Back end projection: depth clamp, scaling products and a pipelined divider per axis.
module prtp_project (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           in_valid_i,
  input  prtp_pkg::pt_t  in_pt_i,
  input  prtp_pkg::cfg_t cfg_i,
  output logic           out_valid_o,
  output prtp_pkg::res_t out_res_o
);

  localparam int QW = prtp_pkg::Q_W;
  localparam logic [QW-1:0] NEG_LIMIT = QW'(1) << (prtp_pkg::SCR_W - 1);
  localparam logic [QW-1:0] POS_LIMIT = NEG_LIMIT - QW'(1);

  typedef struct packed {
    logic [prtp_pkg::MAG_W-1:0] rem;
    logic [QW-1:0]              quo;
    logic                       neg;
    logic                       ovf;
  } dlane_t;

  // depth clamp
  logic [prtp_pkg::NEAR_W-1:0] near1;
  prtp_pkg::coord_t            zc, near_s;
  logic [prtp_pkg::D_W-1:0]    d_n, d1_q;
  prtp_pkg::pt_t               p1_q;
  logic                        v1_q;

  always_comb begin
    near1  = (cfg_i.near_depth == '0) ? prtp_pkg::NEAR_W'(1) : cfg_i.near_depth;
    zc     = in_pt_i.z;
    near_s = {{(prtp_pkg::COORD_W - prtp_pkg::NEAR_W){1'b0}}, near1};
    d_n    = (zc > near_s) ? prtp_pkg::D_W'(zc) : prtp_pkg::D_W'(near1);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      d1_q <= d_n;
      p1_q <= in_pt_i;
    end
  end

  // centre * depth and coordinate * focal scale
  logic [prtp_pkg::CTR_W-1:0]        cxc, cyc;
  prtp_pkg::coord_t                  x1, y1;
  logic signed [prtp_pkg::FOCAL_W:0] fs;
  logic [prtp_pkg::CD_W-1:0]         cdx_q, cdy_q;
  logic signed [prtp_pkg::NF_W-1:0]  nfx_q, nfy_q;
  logic [prtp_pkg::D_W-1:0]          d2_q;
  prtp_pkg::pt_t                     p2_q;
  logic                              v2_q;

  assign cxc = cfg_i.width[prtp_pkg::WIDTH_W-1:1];
  assign cyc = cfg_i.height[prtp_pkg::WIDTH_W-1:1];
  assign x1  = p1_q.x;
  assign y1  = p1_q.y;
  assign fs  = {1'b0, cfg_i.focal};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cdx_q <= prtp_pkg::CD_W'(cxc) * prtp_pkg::CD_W'(d1_q);
      cdy_q <= prtp_pkg::CD_W'(cyc) * prtp_pkg::CD_W'(d1_q);
      nfx_q <= prtp_pkg::NF_W'(x1) * prtp_pkg::NF_W'(fs);
      nfy_q <= prtp_pkg::NF_W'(y1) * prtp_pkg::NF_W'(fs);
      d2_q  <= d1_q;
      p2_q  <= p1_q;
    end
  end

  // numerators, y inverted
  logic signed [prtp_pkg::NUM_W-1:0] cdx_s, cdy_s, nfx_s, nfy_s, numx_q, numy_q;
  logic [prtp_pkg::D_W-1:0]          d3_q;
  prtp_pkg::pt_t                     p3_q;
  logic                              v3_q;

  always_comb begin
    cdx_s = {{(prtp_pkg::NUM_W - prtp_pkg::CD_W){1'b0}}, cdx_q};
    cdy_s = {{(prtp_pkg::NUM_W - prtp_pkg::CD_W){1'b0}}, cdy_q};
    nfx_s = prtp_pkg::NUM_W'(nfx_q);
    nfy_s = prtp_pkg::NUM_W'(nfy_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      numx_q <= cdx_s + nfx_s;
      numy_q <= cdy_s - nfy_s;
      d3_q   <= d2_q;
      p3_q   <= p2_q;
    end
  end

  // sign and magnitude
  logic [prtp_pkg::MAG_W-1:0] magx_q, magy_q;
  logic                       negx_q, negy_q;
  logic [prtp_pkg::D_W-1:0]   d4_q;
  prtp_pkg::pt_t              p4_q;
  logic                       v4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      negx_q <= numx_q[prtp_pkg::NUM_W-1];
      negy_q <= numy_q[prtp_pkg::NUM_W-1];
      magx_q <= numx_q[prtp_pkg::NUM_W-1] ? prtp_pkg::MAG_W'(-numx_q)
                                          : prtp_pkg::MAG_W'(numx_q);
      magy_q <= numy_q[prtp_pkg::NUM_W-1] ? prtp_pkg::MAG_W'(-numy_q)
                                          : prtp_pkg::MAG_W'(numy_q);
      d4_q   <= d3_q;
      p4_q   <= p3_q;
    end
  end

  // divider lanes: entry stage flags a quotient that will saturate anyway
  dlane_t                   lx_q [QW+1];
  dlane_t                   ly_q [QW+1];
  logic [prtp_pkg::D_W-1:0] dd_q [QW+1];
  prtp_pkg::pt_t            dp_q [QW+1];
  logic [QW:0]              dv_q;
  logic [prtp_pkg::CMP_W-1:0] dlim;

  assign dlim = {d4_q, {QW{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lx_q[0].rem <= magx_q;
      lx_q[0].quo <= '0;
      lx_q[0].neg <= negx_q;
      lx_q[0].ovf <= prtp_pkg::CMP_W'(magx_q) >= dlim;
      ly_q[0].rem <= magy_q;
      ly_q[0].quo <= '0;
      ly_q[0].neg <= negy_q;
      ly_q[0].ovf <= prtp_pkg::CMP_W'(magy_q) >= dlim;
      dd_q[0]     <= d4_q;
      dp_q[0]     <= p4_q;
    end
  end

  // one restoring quotient bit per stage, most significant first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int SH = QW - 1 - k;
    logic [prtp_pkg::CMP_W-1:0] trial, rx, ry;
    dlane_t                     nx, ny;
    always_comb begin
      trial = prtp_pkg::CMP_W'(dd_q[k]) << SH;
      rx    = prtp_pkg::CMP_W'(lx_q[k].rem);
      ry    = prtp_pkg::CMP_W'(ly_q[k].rem);
      nx    = lx_q[k];
      ny    = ly_q[k];
      if (rx >= trial) begin
        nx.rem = prtp_pkg::MAG_W'(rx - trial);
        nx.quo = {lx_q[k].quo[QW-2:0], 1'b1};
      end else begin
        nx.quo = {lx_q[k].quo[QW-2:0], 1'b0};
      end
      if (ry >= trial) begin
        ny.rem = prtp_pkg::MAG_W'(ry - trial);
        ny.quo = {ly_q[k].quo[QW-2:0], 1'b1};
      end else begin
        ny.quo = {ly_q[k].quo[QW-2:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        lx_q[k+1] <= nx;
        ly_q[k+1] <= ny;
        dd_q[k+1] <= dd_q[k];
        dp_q[k+1] <= dp_q[k];
      end
    end
  end

  // apply sign, truncate toward zero and saturate to the screen range
  function automatic prtp_pkg::scr_t finish(input dlane_t l);
    prtp_pkg::scr_t r;
    if (l.ovf) begin
      r = l.neg ? prtp_pkg::SCR_MIN : prtp_pkg::SCR_MAX;
    end else if (!l.neg) begin
      r = (l.quo > POS_LIMIT) ? prtp_pkg::SCR_MAX : prtp_pkg::SCR_W'(l.quo);
    end else begin
      r = (l.quo > NEG_LIMIT) ? prtp_pkg::SCR_MIN : prtp_pkg::SCR_W'(-l.quo);
    end
    return r;
  endfunction

  prtp_pkg::res_t f_q;
  logic           fv_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f_q.x  <= dp_q[QW].x;
      f_q.y  <= dp_q[QW].y;
      f_q.z  <= dp_q[QW].z;
      f_q.sx <= finish(lx_q[QW]);
      f_q.sy <= finish(ly_q[QW]);
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      dv_q <= '0;
      fv_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      dv_q <= {dv_q[QW-1:0], v4_q};
      fv_q <= dv_q[QW];
    end
  end

  assign out_valid_o = fv_q;
  assign out_res_o   = f_q;

endmodule

FILE: sv/point_rotate_translate_project.sv
// A pushed word reaches the result ports through the back pipeline and the result queue (empty falls).
// Throughput: one word per cycle; the back pipeline (16 CORDIC stages, products,
// 17-stage divider) holds as a whole only while the two-entry result queue is full.
// Reset: rst_ni async active low clears queues and stage valids, registers take
// width 800, height 600, focal 500, near depth 256.
module point_rotate_translate_project (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic [prtp_pkg::MODE_W-1:0]           mode_i,
  input  logic signed [prtp_pkg::COORD_W-1:0]   in_x_i,
  input  logic signed [prtp_pkg::COORD_W-1:0]   in_y_i,
  input  logic signed [prtp_pkg::COORD_W-1:0]   in_z_i,
  input  logic signed [prtp_pkg::ANGLE_W-1:0]   angle_i,
  input  logic signed [prtp_pkg::COORD_W-1:0]   offset_i,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [prtp_pkg::COORD_W-1:0]   out_x_o,
  output logic signed [prtp_pkg::COORD_W-1:0]   out_y_o,
  output logic signed [prtp_pkg::COORD_W-1:0]   out_z_o,
  output logic signed [prtp_pkg::SCR_W-1:0]     screen_x_o,
  output logic signed [prtp_pkg::SCR_W-1:0]     screen_y_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [prtp_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [prtp_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int QWORD_W = $bits(prtp_pkg::qword_t);
  localparam int RES_W   = $bits(prtp_pkg::res_t);

  // configuration registers
  prtp_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width      <= prtp_pkg::RST_WIDTH;
      cfg_q.height     <= prtp_pkg::RST_HEIGHT;
      cfg_q.focal      <= prtp_pkg::RST_FOCAL;
      cfg_q.near_depth <= prtp_pkg::RST_NEAR;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        prtp_pkg::REG_WIDTH:  cfg_q.width      <= cfg_data_i[prtp_pkg::WIDTH_W-1:0];
        prtp_pkg::REG_HEIGHT: cfg_q.height     <= cfg_data_i[prtp_pkg::WIDTH_W-1:0];
        prtp_pkg::REG_FOCAL:  cfg_q.focal      <= cfg_data_i[prtp_pkg::FOCAL_W-1:0];
        prtp_pkg::REG_NEAR:   cfg_q.near_depth <= cfg_data_i[prtp_pkg::NEAR_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  logic             qpush, qfull, qempty, qpop;
  prtp_pkg::qword_t qword_in, qword_out;
  logic [QWORD_W-1:0] qrdata;

  prtp_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .full_o   (full),
    .mode_i   (mode_i),
    .in_x_i   (in_x_i),
    .in_y_i   (in_y_i),
    .in_z_i   (in_z_i),
    .angle_i  (angle_i),
    .offset_i (offset_i),
    .qfull_i  (qfull),
    .qpush_o  (qpush),
    .qword_o  (qword_in)
  );

  // decoupling queue between front and back
  prtp_fifo #(.WIDTH(QWORD_W)) u_midq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (qpush),
    .wdata_i (qword_in),
    .full_o  (qfull),
    .pop_i   (qpop),
    .rdata_o (qrdata),
    .empty_o (qempty)
  );

  assign qword_out = qrdata;

  // back pipeline advances while the result queue has room
  logic           en, ofull;
  logic           rv, pv;
  prtp_pkg::pt_t  rpt;
  prtp_pkg::res_t pres, ores;
  logic [RES_W-1:0] ordata;

  assign en   = !ofull;
  assign qpop = en && !qempty;

  prtp_rotate u_rotate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (!qempty),
    .in_word_i   (qword_out),
    .out_valid_o (rv),
    .out_pt_o    (rpt)
  );

  prtp_project u_project (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .in_valid_i  (rv),
    .in_pt_i     (rpt),
    .cfg_i       (cfg_q),
    .out_valid_o (pv),
    .out_res_o   (pres)
  );

  // result queue
  prtp_fifo #(.WIDTH(RES_W)) u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (en && pv),
    .wdata_i (pres),
    .full_o  (ofull),
    .pop_i   (pop),
    .rdata_o (ordata),
    .empty_o (empty)
  );

  assign ores       = ordata;
  assign out_x_o    = ores.x;
  assign out_y_o    = ores.y;
  assign out_z_o    = ores.z;
  assign screen_x_o = ores.sx;
  assign screen_y_o = ores.sy;

endmodule

FILE: bench/tb_point_rotate_translate_project.sv
// Testbench for point_rotate_translate_project: predicted transform and projection checks.
`timescale 1ns / 100ps
module tb_point_rotate_translate_project;

  localparam int HOLD_CYCLES = 300;
  localparam int LIMIT_CYCLES = 600000;
  localparam int DRAIN_CYCLES = 80;

  // the one mode code that has no operation of its own, and indexes past the last register
  localparam logic [prtp_pkg::MODE_W-1:0]    MODE_UNUSED = 3'd7;
  localparam logic [prtp_pkg::CFG_IDX_W-1:0] REG_NONE_LO = 8'd4;
  localparam logic [prtp_pkg::CFG_IDX_W-1:0] REG_NONE_HI = 8'd255;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [prtp_pkg::MODE_W-1:0] mode_i = '0;
  logic signed [prtp_pkg::COORD_W-1:0] in_x_i = '0, in_y_i = '0, in_z_i = '0, offset_i = '0;
  logic signed [prtp_pkg::ANGLE_W-1:0] angle_i = '0;
  logic empty;
  logic pop = 1'b0;
  logic signed [prtp_pkg::COORD_W-1:0] out_x_o, out_y_o, out_z_o;
  logic signed [prtp_pkg::SCR_W-1:0] screen_x_o, screen_y_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [prtp_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [prtp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;

  // shadow copy of the configuration
  logic [prtp_pkg::WIDTH_W-1:0] cur_width = prtp_pkg::RST_WIDTH;
  logic [prtp_pkg::WIDTH_W-1:0] cur_height = prtp_pkg::RST_HEIGHT;
  logic [prtp_pkg::FOCAL_W-1:0] cur_focal = prtp_pkg::RST_FOCAL;
  logic [prtp_pkg::NEAR_W-1:0]  cur_near = prtp_pkg::RST_NEAR;

  prtp_pkg::res_t pending_points[$];
  int   mismatch_count = 0;
  bit   idle_on = 1'b1;
  bit   hold_rx = 1'b0;
  longint cycle_count = 0;

  point_rotate_translate_project u_dut (
    .clk_i, .rst_ni, .push, .full, .mode_i, .in_x_i, .in_y_i, .in_z_i, .angle_i,
    .offset_i, .empty, .pop, .out_x_o, .out_y_o, .out_z_o, .screen_x_o, .screen_y_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic longint clamp_w(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // CORDIC cos/sin in Q30 from an angle in 2^-7 degree
  task automatic cordic_sincos(input longint ang, output longint c, output longint s);
    longint a, x, y, t, full_t, half_t, qtr_t;
    longint atan_v;
    bit flip;
    full_t = longint'(360) <<< prtp_pkg::ANG_SCALE_BITS;
    half_t = longint'(180) <<< prtp_pkg::ANG_SCALE_BITS;
    qtr_t = longint'(90) <<< prtp_pkg::ANG_SCALE_BITS;
    a = ang * (longint'(1) <<< prtp_pkg::ANG_SHIFT);
    flip = 1'b0;
    x = 652032874;
    y = 0;
    a = a % full_t;
    if (a < 0) a = a + full_t;
    if (a > half_t) a = a - full_t;
    if (a > qtr_t) begin
      a = a - half_t;
      flip = 1'b1;
    end else if (a <= -qtr_t) begin
      a = a + half_t;
      flip = 1'b1;
    end
    for (int i = 0; i < prtp_pkg::CORDIC_STEPS; i++) begin
      atan_v = longint'(prtp_pkg::ATAN_TAB[i]);
      if (a >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        a = a - atan_v;
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        a = a + atan_v;
      end
      x = t;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = x;
    s = y;
  endtask

  function automatic longint round_mac(input longint p, input longint q);
    return clamp_w((p + q + (longint'(1) <<< (prtp_pkg::PROD_SHIFT - 1)))
                   >>> prtp_pkg::PROD_SHIFT, prtp_pkg::COORD_W);
  endfunction

  function automatic longint to_screen(input longint ctr, input longint v, input longint d,
                                       input bit invert);
    longint n, num;
    n = v * longint'(cur_focal);
    num = invert ? ctr * d - n : ctr * d + n;
    return clamp_w(num / d, prtp_pkg::SCR_W);
  endfunction

  // expected transformed point and its projection
  task automatic predict_point(input logic [prtp_pkg::MODE_W-1:0] md,
                               input prtp_pkg::coord_t px, input prtp_pkg::coord_t py,
                               input prtp_pkg::coord_t pz,
                               input logic signed [prtp_pkg::ANGLE_W-1:0] ang,
                               input prtp_pkg::coord_t off, output prtp_pkg::res_t r);
    longint x, y, z, nx, ny, nz, c, s, d;
    x = px; y = py; z = pz;
    nx = x; ny = y; nz = z;
    c = 0; s = 0;
    if (md <= prtp_pkg::MODE_ROT_Z) cordic_sincos(longint'(ang), c, s);
    case (md)
      prtp_pkg::MODE_ROT_X: begin
        ny = round_mac(y * c, -(z * s));
        nz = round_mac(y * s, z * c);
      end
      prtp_pkg::MODE_ROT_Y: begin
        nx = round_mac(x * c, z * s);
        nz = round_mac(-(x * s), z * c);
      end
      prtp_pkg::MODE_ROT_Z: begin
        nx = round_mac(x * c, -(y * s));
        ny = round_mac(x * s, y * c);
      end
      prtp_pkg::MODE_MOVE_X: nx = clamp_w(x + longint'(off), prtp_pkg::COORD_W);
      prtp_pkg::MODE_MOVE_Y: ny = clamp_w(y + longint'(off), prtp_pkg::COORD_W);
      prtp_pkg::MODE_MOVE_Z: nz = clamp_w(z + longint'(off), prtp_pkg::COORD_W);
      default: ;
    endcase
    d = (cur_near == 0) ? 1 : longint'(cur_near);
    if (nz > d) d = nz;
    r.x = prtp_pkg::coord_t'(nx);
    r.y = prtp_pkg::coord_t'(ny);
    r.z = prtp_pkg::coord_t'(nz);
    r.sx = prtp_pkg::scr_t'(to_screen(longint'(cur_width >> 1), nx, d, 1'b0));
    r.sy = prtp_pkg::scr_t'(to_screen(longint'(cur_height >> 1), ny, d, 1'b1));
  endtask

  // send one word; push stays high between back-to-back words
  task automatic send_point(input logic [prtp_pkg::MODE_W-1:0] md,
                            input prtp_pkg::coord_t px, input prtp_pkg::coord_t py,
                            input prtp_pkg::coord_t pz,
                            input logic signed [prtp_pkg::ANGLE_W-1:0] ang,
                            input prtp_pkg::coord_t off);
    prtp_pkg::res_t r;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    push <= 1'b1;
    mode_i <= md;
    in_x_i <= px;
    in_y_i <= py;
    in_z_i <= pz;
    angle_i <= ang;
    offset_i <= off;
    do @(posedge clk_i); while (full);
    predict_point(md, px, py, pz, ang, off, r);
    pending_points.insert(pending_points.size(), r);
  endtask

  task automatic stop_push();
    push <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_points.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [prtp_pkg::CFG_IDX_W-1:0] idx,
                           input logic [prtp_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      prtp_pkg::REG_WIDTH:  cur_width = val[prtp_pkg::WIDTH_W-1:0];
      prtp_pkg::REG_HEIGHT: cur_height = val[prtp_pkg::WIDTH_W-1:0];
      prtp_pkg::REG_FOCAL:  cur_focal = val[prtp_pkg::FOCAL_W-1:0];
      prtp_pkg::REG_NEAR:   cur_near = val[prtp_pkg::NEAR_W-1:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic prtp_pkg::coord_t rand_coord();
    case ($urandom_range(0, 4))
      0: return prtp_pkg::coord_t'($urandom);
      1: return prtp_pkg::coord_t'($urandom_range(0, 131072)) - 24'sd65536;
      2: return $urandom_range(0, 1) ? prtp_pkg::COORD_MAX : prtp_pkg::COORD_MIN;
      3: return prtp_pkg::coord_t'($urandom_range(0, 8388607));
      default: return prtp_pkg::coord_t'($urandom_range(0, 4096)) - 24'sd2048;
    endcase
  endfunction

  function automatic logic signed [prtp_pkg::ANGLE_W-1:0] rand_angle();
    return prtp_pkg::ANGLE_W'(int'($urandom_range(0, 92160)) - 46080);
  endfunction

  task automatic send_random();
    send_point(prtp_pkg::MODE_W'($urandom_range(0, 7)), rand_coord(), rand_coord(),
               rand_coord(), rand_angle(), rand_coord());
  endtask

  // every mode, field extremes and the named corner cases
  task automatic test_directed();
    send_point(prtp_pkg::MODE_ROT_X, 24'sd256, 24'sd512, 24'sd1024, 17'sd11520, 24'sd0);
    send_point(prtp_pkg::MODE_ROT_Y, 24'sd256, 24'sd512, 24'sd1024, -17'sd11520, 24'sd0);
    send_point(prtp_pkg::MODE_ROT_Z, 24'sd256, 24'sd512, 24'sd1024, 17'sd23040, 24'sd0);
    send_point(prtp_pkg::MODE_ROT_X, prtp_pkg::COORD_MAX, prtp_pkg::COORD_MAX,
               prtp_pkg::COORD_MAX, 17'sd46080, 24'sd0);
    send_point(prtp_pkg::MODE_ROT_Y, prtp_pkg::COORD_MIN, prtp_pkg::COORD_MIN,
               prtp_pkg::COORD_MIN, -17'sd46080, 24'sd0);
    send_point(prtp_pkg::MODE_ROT_Z, prtp_pkg::COORD_MAX, prtp_pkg::COORD_MIN, 24'sd512,
               17'sd5760, 24'sd0);
    send_point(prtp_pkg::MODE_ROT_X, prtp_pkg::COORD_MIN, prtp_pkg::COORD_MAX,
               prtp_pkg::COORD_MIN, 17'sd0, 24'sd0);
    send_point(prtp_pkg::MODE_ROT_Z, prtp_pkg::COORD_MAX, prtp_pkg::COORD_MAX, 24'sd256,
               -17'sd23040, 24'sd0);
    // angles past a half turn
    send_point(prtp_pkg::MODE_ROT_Y, 24'sd1000, 24'sd0, 24'sd3000, 17'sd46079, 24'sd0);
    send_point(prtp_pkg::MODE_ROT_Z, 24'sd1000, 24'sd2000, 24'sd3000, -17'sd34561, 24'sd0);
    // translation with overflow both ways
    send_point(prtp_pkg::MODE_MOVE_X, prtp_pkg::COORD_MAX, 24'sd0, 24'sd256, -17'sd1,
               prtp_pkg::COORD_MAX);
    send_point(prtp_pkg::MODE_MOVE_Y, 24'sd0, prtp_pkg::COORD_MIN, 24'sd256, 17'sd0,
               prtp_pkg::COORD_MIN);
    send_point(prtp_pkg::MODE_MOVE_Z, 24'sd0, 24'sd0, prtp_pkg::COORD_MAX, 17'sd0,
               prtp_pkg::COORD_MAX);
    send_point(prtp_pkg::MODE_MOVE_Z, 24'sd0, 24'sd0, prtp_pkg::COORD_MIN, 17'sd0,
               prtp_pkg::COORD_MIN);
    send_point(prtp_pkg::MODE_MOVE_X, 24'sd100, 24'sd0, 24'sd256, 17'sd0, -24'sd300);
    // pass and the unused mode; depth below near, screen overflow
    send_point(prtp_pkg::MODE_PASS, prtp_pkg::COORD_MAX, prtp_pkg::COORD_MIN, 24'sd1,
               17'sd0, 24'sd0);
    send_point(MODE_UNUSED, prtp_pkg::COORD_MIN, prtp_pkg::COORD_MAX, -24'sd5000,
               -17'sd1, -24'sd1);
    send_point(prtp_pkg::MODE_PASS, 24'sd0, 24'sd0, 24'sd0, 17'sd0, 24'sd0);
    send_point(prtp_pkg::MODE_PASS, 24'sd1280, -24'sd640, prtp_pkg::COORD_MAX, 17'sd0,
               24'sd0);
    send_point(MODE_UNUSED, -24'sd1, -24'sd1, -24'sd1, -17'sd1, -24'sd1);
    stop_push();
    wait_drained();
  endtask

  // several register settings, extremes, zeros and bad indexes
  task automatic test_registers();
    logic [prtp_pkg::CFG_DATA_W-1:0] setting[6][4] = '{
      '{16'd4096, 16'd4096, 16'd4095, 16'd65535},
      '{16'd1, 16'd1, 16'd1, 16'd1},
      '{16'd0, 16'd0, 16'd0, 16'd0},
      '{16'hFFFF, 16'hE001, 16'hF7FF, 16'd2},
      '{16'd1920, 16'd1080, 16'd800, 16'd512},
      '{16'd800, 16'd600, 16'd500, 16'd256}
    };
    for (int k = 0; k < 7; k++) begin
      for (int r = 0; r < 4; r++) begin
        if (k < 6) write_reg(prtp_pkg::CFG_IDX_W'(r), setting[k][r]);
        else write_reg(prtp_pkg::CFG_IDX_W'(r), prtp_pkg::CFG_DATA_W'($urandom));
      end
      write_reg(REG_NONE_LO, prtp_pkg::CFG_DATA_W'($urandom));
      write_reg(REG_NONE_HI, 16'd1);
      repeat (40) send_random();
      stop_push();
      wait_drained();
    end
  endtask

  // receiver stalls long so the block fills and holds off the sender
  task automatic test_backpressure();
    hold_rx = 1'b1;
    repeat (80) send_random();
    stop_push();
    wait_drained();
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      send_random();
      // sender pauses until the block has emptied
      if (i == count / 2) begin
        stop_push();
        wait_drained();
      end
    end
    stop_push();
    wait_drained();
  endtask

  // receiver: bursts of pop and idle, or a long hold when asked
  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_rx) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_rx = 1'b0;
      end else if (idle_on && $urandom_range(0, 2) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        pop <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk_i);
      end
    end
  end

  // compare each popped word against the oldest prediction
  always @(posedge clk_i) begin
    prtp_pkg::res_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_points.size() == 0) begin
        $error("unexpected word: x %0d y %0d z %0d", out_x_o, out_y_o, out_z_o);
        mismatch_count++;
      end else begin
        e = pending_points.pop_front();
        if (out_x_o !== e.x) begin
          $error("out_x expected %0d actual %0d", e.x, out_x_o);
          mismatch_count++;
        end
        if (out_y_o !== e.y) begin
          $error("out_y expected %0d actual %0d", e.y, out_y_o);
          mismatch_count++;
        end
        if (out_z_o !== e.z) begin
          $error("out_z expected %0d actual %0d", e.z, out_z_o);
          mismatch_count++;
        end
        if (screen_x_o !== e.sx) begin
          $error("screen_x expected %0d actual %0d", e.sx, screen_x_o);
          mismatch_count++;
        end
        if (screen_y_o !== e.sy) begin
          $error("screen_y expected %0d actual %0d", e.sy, screen_y_o);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_registers();
    test_backpressure();
    test_random(1000);
    // final stretch without idling
    idle_on = 1'b0;
    test_random(300);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_points.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
